// ----- hw/rtl/particle_record_update_assert.svh -----
// ---------------------------------------------------------------------------
// particle_record_update_assert.svh
// Assertion macros shared by the particle record updater.
// ---------------------------------------------------------------------------
`ifndef PARTICLE_RECORD_UPDATE_ASSERT_SVH
`define PARTICLE_RECORD_UPDATE_ASSERT_SVH

// Checks that the condition holds on every clock edge outside reset.
`define PRU_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/pru_pkg.sv -----
// ---------------------------------------------------------------------------
// pru_pkg
// Types and constants of the particle record updater.
// ---------------------------------------------------------------------------
package pru_pkg;

    // Frame geometry.
    localparam int NUM_GROUPS      = 8;
    localparam int SLOTS_PER_GROUP = 16;
    localparam int FRAME_TOTAL     = NUM_GROUPS * SLOTS_PER_GROUP;

    // Particle phases.
    localparam logic [15:0] MODE_FLYING   = 16'd0;
    localparam logic [15:0] MODE_FADING   = 16'd1;
    localparam logic [15:0] MODE_FINISHED = 16'd2;

    // Update steps.
    localparam logic [15:0] SCALE_STEP = 16'h0010;
    localparam logic [15:0] FADE_SPIN  = 16'h0080;
    localparam logic [32:0] FADE_STEP  = 33'd8;
    localparam logic [15:0] LIFE_WRAP  = 16'hFFFF;
    localparam logic [7:0]  COUNT_MAX  = 8'hFF;

    // Bus widths.
    localparam int S_TDATA_W = 208;
    localparam int M_TDATA_W = 160;

    // One particle record as it enters the block.
    typedef struct packed {
        logic [15:0]        mode;
        logic [15:0]        life;
        logic [15:0]        angle;
        logic [15:0]        angle_rate;
        logic [15:0]        scale;
        logic signed [31:0] velocity;
        logic signed [31:0] accel;
        logic signed [31:0] position;
        logic signed [31:0] alpha;
    } rec_in_t;

    // One updated particle record.
    typedef struct packed {
        logic [15:0]        mode;
        logic [15:0]        life;
        logic [15:0]        angle;
        logic [15:0]        scale;
        logic signed [31:0] velocity;
        logic signed [31:0] position;
        logic signed [31:0] alpha;
    } rec_out_t;

    // Control from the pipeline to the frame counter.
    typedef struct packed {
        logic advance;
        logic finished;
        logic last;
    } cnt_ctrl_t;

endpackage

// ----- hw/rtl/pru_update.sv -----
// ---------------------------------------------------------------------------
// pru_update
// Combinational update of one particle record according to its phase.
// ---------------------------------------------------------------------------
module pru_update (
    input  pru_pkg::rec_in_t  rec_i,
    output pru_pkg::rec_out_t rec_o,
    output logic              finished_o
);
    import pru_pkg::*;

    logic [15:0] life_dec;
    logic [31:0] vel_sum;
    logic [32:0] alpha_dec;

    // Arithmetic used by the phase arms.
    assign life_dec  = rec_i.life - 16'd1;
    assign vel_sum   = rec_i.velocity + rec_i.accel;
    assign alpha_dec = {rec_i.alpha[31], rec_i.alpha} - FADE_STEP;

    // Phase selection; by default the record passes through.
    always_comb begin
        rec_o.mode     = rec_i.mode;
        rec_o.life     = rec_i.life;
        rec_o.angle    = rec_i.angle;
        rec_o.scale    = rec_i.scale;
        rec_o.velocity = rec_i.velocity;
        rec_o.position = rec_i.position;
        rec_o.alpha    = rec_i.alpha;
        finished_o     = 1'b0;
        unique case (rec_i.mode)
            MODE_FLYING: begin
                rec_o.velocity = vel_sum;
                rec_o.position = rec_i.position + vel_sum;
                rec_o.life     = life_dec;
                rec_o.angle    = rec_i.angle + rec_i.angle_rate;
                rec_o.scale    = rec_i.scale + SCALE_STEP;
                if (life_dec == LIFE_WRAP) begin
                    rec_o.mode = MODE_FADING;
                end
            end
            MODE_FADING: begin
                rec_o.angle = rec_i.angle + FADE_SPIN;
                if (alpha_dec[32]) begin
                    rec_o.alpha = 32'sd0;
                    rec_o.mode  = MODE_FINISHED;
                end else begin
                    rec_o.alpha = alpha_dec[31:0];
                end
            end
            MODE_FINISHED: begin
                finished_o = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- hw/rtl/pru_frame_count.sv -----
// ---------------------------------------------------------------------------
// pru_frame_count
// Counts finished particles over a frame and judges the frame complete.
// ---------------------------------------------------------------------------
module pru_frame_count (
    input  logic                aclk,
    input  logic                aresetn,
    input  pru_pkg::cnt_ctrl_t  ctrl_i,
    output logic                all_finished_o,
    output logic [7:0]          count_o
);
    import pru_pkg::*;

    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic [7:0] count_inc;

    // Saturating count including the current item.
    assign count_inc = (ctrl_i.finished && count_reg != COUNT_MAX) ?
                       count_reg + 8'd1 : count_reg;

    // Frame judgement for the item moving to the output.
    assign all_finished_o = ctrl_i.last && (32'(count_inc) == FRAME_TOTAL);

    always_comb begin
        count_next = count_reg;
        if (ctrl_i.advance) begin
            count_next = ctrl_i.last ? 8'd0 : count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 8'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign count_o = count_reg;

endmodule

// ----- hw/rtl/particle_record_update.sv -----
// ---------------------------------------------------------------------------
// particle_record_update
// Streaming updater: one particle record in, one updated record out.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake                    Contents
//  s_axis   in         s_axis_tvalid/s_axis_tready  record in tdata, tlast
//  m_axis   out        m_axis_tvalid/m_axis_tready  record in tdata, tuser
//
// One record per clock cycle sustained while m_axis_tready holds; an accepted
// record passes through the input register and the single update stage into
// the result register, from which it is offered.
// Synchronous active-low reset empties both registers and clears the count.
// A stalled result holds in the result register while the input register
// still takes one more record.
// ---------------------------------------------------------------------------
`include "particle_record_update_assert.svh"

module particle_record_update (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // mode_in, life_in, angle_in, angle_rate, scale_in, velocity_in,
    // accel, position_in, alpha_in
    input  logic [pru_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // mode_out, life_out, angle_out, scale_out, velocity_out,
    // position_out, alpha_out
    output logic [pru_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // all_finished
    output logic                           m_axis_tuser
);
    import pru_pkg::*;

    logic      in_valid_reg;
    logic      in_valid_next;
    rec_in_t   in_rec_reg;
    logic      in_last_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    rec_out_t  out_rec_reg;
    logic      out_done_reg;
    logic      out_last_reg;
    logic      s_accept;
    logic      advance;
    rec_in_t   s_rec;
    rec_out_t  upd_rec;
    logic      upd_finished;
    logic      all_finished;
    logic [7:0] count;
    cnt_ctrl_t cnt_ctrl;

    // Unpack the input word, first field in the lowest bits.
    assign s_rec.mode       = s_axis_tdata[15:0];
    assign s_rec.life       = s_axis_tdata[31:16];
    assign s_rec.angle      = s_axis_tdata[47:32];
    assign s_rec.angle_rate = s_axis_tdata[63:48];
    assign s_rec.scale      = s_axis_tdata[79:64];
    assign s_rec.velocity   = s_axis_tdata[111:80];
    assign s_rec.accel      = s_axis_tdata[143:112];
    assign s_rec.position   = s_axis_tdata[175:144];
    assign s_rec.alpha      = s_axis_tdata[207:176];

    // Pipeline flow control.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_rec_reg  <= s_rec;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Record update.
    pru_update u_update (
        .rec_i      (in_rec_reg),
        .rec_o      (upd_rec),
        .finished_o (upd_finished)
    );

    // Frame counter.
    assign cnt_ctrl.advance  = advance;
    assign cnt_ctrl.finished = upd_finished;
    assign cnt_ctrl.last     = in_last_reg;

    pru_frame_count u_frame_count (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl_i         (cnt_ctrl),
        .all_finished_o (all_finished),
        .count_o        (count)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_rec_reg  <= upd_rec;
            out_done_reg <= all_finished;
            out_last_reg <= in_last_reg;
        end
    end

    // Pack the result word, first field in the lowest bits.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_rec_reg.alpha, out_rec_reg.position,
                            out_rec_reg.velocity, out_rec_reg.scale,
                            out_rec_reg.angle, out_rec_reg.life,
                            out_rec_reg.mode};
    assign m_axis_tuser  = out_done_reg;

    // Checks on the pipeline and the frame count.
    `PRU_ASSERT_ALWAYS(a_empty_ready, in_valid_reg || s_axis_tready, "empty stage not ready")
    `PRU_ASSERT_ALWAYS(a_done_on_last, !m_axis_tvalid || out_last_reg || !m_axis_tuser, "flag off last")
    `PRU_ASSERT_NEXT(a_count_clear, advance && in_last_reg, count == 8'd0, "count not cleared")

endmodule
